// File: rtl/sibd_pkg.sv
// Package for the signed integer to base digits converter.
// Shared constants, controller state type and the controller/datapath command and
// status structs. No dependencies.
package sibd_pkg;

    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int MAX_BASE     = 16;
    localparam int MAX_DIGITS   = 32;
    localparam int DIGIT_W      = $clog2(MAX_BASE);
    localparam int BASE_W       = DIGIT_W + 1;
    localparam int STACK_IDX_W  = $clog2(MAX_DIGITS);
    localparam int COUNT_W      = STACK_IDX_W + 1;
    localparam int ALPHA_WORD_W = 64;

    // restoring division of the magnitude, this many quotient bits per cycle
    localparam int DIV_BITS     = 8;
    localparam int DIV_CYCLES   = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

    localparam logic [CHAR_W-1:0] CHAR_MINUS     = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS      = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI  = 8'd126;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } sibd_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_bad;
        logic emit_sign;
        logic emit_digit;
    } sibd_cmd_t;

    typedef struct packed {
        logic alpha_ok;
        logic div_last;
        logic div_done;
        logic neg;
        logic last_digit;
        logic stack_empty;
        logic out_free;
    } sibd_status_t;

endpackage

// File: rtl/signed_int_to_base_digits_unit.sv
// Top level of the signed integer to base digits converter.
// Joins sibd_ctrl and sibd_datapath; depends on sibd_pkg.
//
// Usage:
//   Configuration: cfg_write with cfg_index 0 (base_length), 1 (digits_low) or
//   2 (digits_high) and cfg_data; the user writes only while the unit is idle (unit does not check).
//   Input: value transfers on in_valid & in_ready. One number is in work at a time.
//   Output: one character per transfer on out_valid & out_ready, minus sign
//   first for negatives, then digits most significant first; last marks the
//   final character. A bad alphabet gives one transfer with out_char 0,
//   last 1 and bad_base 1.
//   Flow: division by the radix yields 8 quotient bits per cycle through one
//   compare/subtract slice; all digits of a number, up to 32, are divided first,
//   then characters leave at one per cycle while the receiver takes them.
//   The final character sits in the output register while the next number is
//   accepted and divided; a stalled receiver holds the output and stalls
//   further character output only.
//   Reset: output empty, controller idle, base_length 2, alphabet zero.
module signed_int_to_base_digits_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sibd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sibd_pkg::ALPHA_WORD_W-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [sibd_pkg::VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sibd_pkg::CHAR_W-1:0]          out_char,
    output logic                                 last,
    output logic                                 bad_base
);

    sibd_pkg::sibd_cmd_t    cmd;
    sibd_pkg::sibd_status_t sts;

    sibd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sibd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .bad_base  (bad_base),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one number at a time: a transfer closes the input until the number is done
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a number is in work");

    // the idle controller always finds an empty digit stack
    a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> sts.stack_empty)
        else $error("digit stack not empty at idle");

    // a bad alphabet result is a lone zero character
    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_base |-> last && (out_char == '0))
        else $error("bad alphabet result malformed");

    // emitting never overruns a waiting result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(cmd.emit_bad || cmd.emit_sign || cmd.emit_digit))
        else $error("output register overwritten while stalled");

endmodule

// File: rtl/sibd_ctrl.sv
// Controller of the base digits converter: sequences load, division, sign and
// digit output. Depends on sibd_pkg.
module sibd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sibd_pkg::sibd_status_t sts,
    output sibd_pkg::sibd_cmd_t   cmd
);

    sibd_pkg::sibd_state_t state_reg;
    sibd_pkg::sibd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sibd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sibd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.alpha_ok ? sibd_pkg::ST_DIVIDE : sibd_pkg::ST_BAD;
                end
            end
            sibd_pkg::ST_BAD:
            begin
                if (sts.out_free)
                begin
                    state_next = sibd_pkg::ST_IDLE;
                end
            end
            sibd_pkg::ST_DIVIDE:
            begin
                if (sts.div_last && sts.div_done)
                begin
                    state_next = sts.neg ? sibd_pkg::ST_SIGN : sibd_pkg::ST_DIGITS;
                end
            end
            sibd_pkg::ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = sibd_pkg::ST_DIGITS;
                end
            end
            sibd_pkg::ST_DIGITS:
            begin
                if (sts.out_free && sts.last_digit)
                begin
                    state_next = sibd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sibd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            sibd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sibd_pkg::ST_BAD:
            begin
                cmd.emit_bad = sts.out_free;
            end
            sibd_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            sibd_pkg::ST_SIGN:
            begin
                cmd.emit_sign = sts.out_free;
            end
            sibd_pkg::ST_DIGITS:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/sibd_datapath.sv
// Datapath of the base digits converter: configuration registers, alphabet check,
// radix divider, digit stack and output register. Depends on sibd_pkg.
module sibd_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [sibd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sibd_pkg::ALPHA_WORD_W-1:0]     cfg_data,
    input  logic signed [sibd_pkg::VALUE_W-1:0]   value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [sibd_pkg::CHAR_W-1:0]           out_char,
    output logic                                  last,
    output logic                                  bad_base,
    input  sibd_pkg::sibd_cmd_t                   cmd,
    output sibd_pkg::sibd_status_t                sts
);

    logic [sibd_pkg::BASE_W-1:0]       base_length_reg;
    logic [sibd_pkg::ALPHA_WORD_W-1:0] digits_low_reg;
    logic [sibd_pkg::ALPHA_WORD_W-1:0] digits_high_reg;

    logic [sibd_pkg::VALUE_W-1:0]      work_reg, work_next;
    logic [sibd_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic [sibd_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [sibd_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic                              neg_reg, neg_next;

    logic                              out_valid_reg, out_valid_next;
    logic [sibd_pkg::CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                              last_reg, last_next;
    logic                              bad_reg, bad_next;

    logic [sibd_pkg::DIGIT_W-1:0]      digit_stack [sibd_pkg::MAX_DIGITS];
    logic [sibd_pkg::DIGIT_W-1:0]      top_digit_reg;

    logic [sibd_pkg::MAX_BASE-1:0][sibd_pkg::CHAR_W-1:0] alphabet;
    logic                              alpha_ok;
    logic [sibd_pkg::VALUE_W-1:0]      div_w;
    logic [sibd_pkg::DIGIT_W-1:0]      div_r;
    logic                              stack_wr;
    logic [sibd_pkg::STACK_IDX_W-1:0]  wr_idx;
    logic [sibd_pkg::STACK_IDX_W-1:0]  rd_idx;
    logic                              div_last;
    logic                              out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg <= sibd_pkg::BASE_RESET;
            digits_low_reg  <= '0;
            digits_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sibd_pkg::CFG_BASE_LENGTH: base_length_reg <= cfg_data[sibd_pkg::BASE_W-1:0];
                sibd_pkg::CFG_DIGITS_LOW:  digits_low_reg  <= cfg_data;
                sibd_pkg::CFG_DIGITS_HIGH: digits_high_reg <= cfg_data;
                default:                   base_length_reg <= base_length_reg;
            endcase
        end
    end

    assign alphabet = {digits_high_reg, digits_low_reg};

    // alphabet check: radix range, printable, no sign characters, no repeats
    always_comb
    begin : alpha_check
        logic [sibd_pkg::CHAR_W-1:0] c;
        alpha_ok = (base_length_reg >= sibd_pkg::BASE_W'(2))
                && (base_length_reg <= sibd_pkg::BASE_W'(sibd_pkg::MAX_BASE));
        for (int i = 0; i < sibd_pkg::MAX_BASE; i++)
        begin
            c = alphabet[i];
            if (sibd_pkg::BASE_W'(i) < base_length_reg)
            begin
                if (c < sibd_pkg::CHAR_PRINT_LO || c > sibd_pkg::CHAR_PRINT_HI
                    || c == sibd_pkg::CHAR_PLUS || c == sibd_pkg::CHAR_MINUS)
                begin
                    alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < sibd_pkg::MAX_BASE; j++)
                begin
                    if (sibd_pkg::BASE_W'(j) < base_length_reg && alphabet[j] == c)
                    begin
                        alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // DIV_BITS steps of restoring division; quotient bits shift in at the bottom
    always_comb
    begin : div_slice
        logic [sibd_pkg::DIGIT_W:0] t;
        div_w = work_reg;
        div_r = rem_reg;
        for (int k = 0; k < sibd_pkg::DIV_BITS; k++)
        begin
            t     = {div_r, div_w[sibd_pkg::VALUE_W-1]};
            div_w = {div_w[sibd_pkg::VALUE_W-2:0], 1'b0};
            if (t >= base_length_reg)
            begin
                div_r    = sibd_pkg::DIGIT_W'(t - base_length_reg);
                div_w[0] = 1'b1;
            end
            else
            begin
                div_r = t[sibd_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign div_last  = (div_cnt_reg == sibd_pkg::DIV_CNT_W'(sibd_pkg::DIV_CYCLES - 1));
    assign out_free  = !out_valid_reg || out_ready;
    assign stack_wr  = cmd.div_step && div_last;
    assign wr_idx    = count_reg[sibd_pkg::STACK_IDX_W-1:0];
    assign rd_idx    = count_next[sibd_pkg::STACK_IDX_W-1:0] - 1'b1;

    always_comb
    begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        count_next     = count_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;

        if (cmd.load)
        begin
            neg_next     = value[sibd_pkg::VALUE_W-1];
            work_next    = value[sibd_pkg::VALUE_W-1] ? (sibd_pkg::VALUE_W'(0) - $unsigned(value))
                                                      : $unsigned(value);
            rem_next     = '0;
            div_cnt_next = '0;
            count_next   = '0;
        end

        if (cmd.div_step)
        begin
            div_cnt_next = div_cnt_reg + 1'b1;
            work_next    = div_w;
            if (div_last)
            begin
                rem_next   = '0;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                rem_next = div_r;
            end
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_bad)
        begin
            out_valid_next = 1'b1;
            out_char_next  = '0;
            last_next      = 1'b1;
            bad_next       = 1'b1;
        end
        else if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            out_char_next  = sibd_pkg::CHAR_MINUS;
            last_next      = 1'b0;
            bad_next       = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = alphabet[top_digit_reg];
            last_next      = (count_reg == sibd_pkg::COUNT_W'(1));
            bad_next       = 1'b0;
            count_next     = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
    end

    // digit stack, least significant digit at entry 0; the read register tracks
    // the next stack top, and a digit pushed in the same cycle goes straight through
    always_ff @(posedge clk)
    begin
        if (stack_wr)
        begin
            digit_stack[wr_idx] <= div_r;
        end
        if (stack_wr && (rd_idx == wr_idx))
        begin
            top_digit_reg <= div_r;
        end
        else
        begin
            top_digit_reg <= digit_stack[rd_idx];
        end
    end

    always_comb
    begin
        sts.alpha_ok    = alpha_ok;
        sts.div_last    = div_last;
        sts.div_done    = (div_w == '0)
                       || (count_reg == sibd_pkg::COUNT_W'(sibd_pkg::MAX_DIGITS - 1));
        sts.neg         = neg_reg;
        sts.last_digit  = (count_reg == sibd_pkg::COUNT_W'(1));
        sts.stack_empty = (count_reg == '0);
        sts.out_free    = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign bad_base  = bad_reg;

endmodule

// File: test/signed_int_to_base_digits_unit_tb.sv
// Testbench for signed_int_to_base_digits_unit: directed cases, then random bursts of
// numbers under changing radix and alphabet settings, every character checked against an
// in-bench predictor. Depends on sibd_pkg and the RTL of the unit only.
module signed_int_to_base_digits_unit_tb;

    localparam logic [sibd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES  = 200;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS  = 26;

    localparam logic [sibd_pkg::ALPHA_WORD_W-1:0] HEX_LO  = 64'h3736_3534_3332_3130;
    localparam logic [sibd_pkg::ALPHA_WORD_W-1:0] HEX_HI  = 64'h4645_4443_4241_3938;
    localparam logic [sibd_pkg::ALPHA_WORD_W-1:0] DEC_HI  = 64'h0000_0000_0000_3938;
    // space and tilde: the printable extremes
    localparam logic [sibd_pkg::ALPHA_WORD_W-1:0] EDGE_LO = 64'h0000_0000_0000_7E20;

    typedef struct packed {
        logic [sibd_pkg::CHAR_W-1:0] ch;
        logic                        last;
        logic                        bad;
    } text_char_t;

    typedef struct {
        logic [sibd_pkg::VALUE_W-1:0] value;
        bit                           drain;  // hold this one back until all text is out
    } number_t;

    typedef enum {
        ALPHA_CLEAN,
        ALPHA_PLUS,
        ALPHA_MINUS,
        ALPHA_REPEAT,
        ALPHA_UNPRINTABLE_LO,
        ALPHA_UNPRINTABLE_HI,
        ALPHA_BAD_RADIX
    } alpha_flaw_t;

    typedef enum {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_write = 1'b0;
    logic [sibd_pkg::CFG_IDX_W-1:0]        cfg_index = sibd_pkg::CFG_BASE_LENGTH;
    logic [sibd_pkg::ALPHA_WORD_W-1:0]     cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic signed [sibd_pkg::VALUE_W-1:0]   value = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [sibd_pkg::CHAR_W-1:0]           out_char;
    logic                                  last;
    logic                                  bad_base;

    // shadow of the unit's registers
    logic [4:0]                            base_len = 5'd2;
    logic [sibd_pkg::ALPHA_WORD_W-1:0]     alpha_lo = '0;
    logic [sibd_pkg::ALPHA_WORD_W-1:0]     alpha_hi = '0;

    number_t    number_queue[$];
    text_char_t pending_chars[$];

    int numbers_sent = 0;
    int chars_checked = 0;
    int rejections_seen = 0;
    int settings_used = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_left = 0;
    int rx_hold = 0;
    int rx_tick = 0;
    rx_mode_t rx_mode = RX_OPEN;

    signed_int_to_base_digits_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last      (last),
        .bad_base  (bad_base)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [sibd_pkg::CHAR_W-1:0] alpha_byte(input logic [3:0] k);
        logic [sibd_pkg::ALPHA_WORD_W-1:0] word;
        word = k[3] ? alpha_hi : alpha_lo;
        return word[k[2:0]*8 +: 8];
    endfunction

    function automatic bit alphabet_valid();
        logic [sibd_pkg::CHAR_W-1:0] c;
        if (base_len < 2 || base_len > sibd_pkg::MAX_BASE)
            return 1'b0;
        for (int i = 0; i < base_len; i++)
        begin
            c = alpha_byte(4'(i));
            if (c < sibd_pkg::CHAR_PRINT_LO || c > sibd_pkg::CHAR_PRINT_HI
                || c == sibd_pkg::CHAR_PLUS || c == sibd_pkg::CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < base_len; j++)
                if (alpha_byte(4'(j)) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Expected text of one number, sign first, digits most significant first.
    task automatic predict_text(input logic [sibd_pkg::VALUE_W-1:0] v);
        logic [3:0]                   stack [sibd_pkg::MAX_DIGITS];
        logic [sibd_pkg::VALUE_W-1:0] mag;
        logic [sibd_pkg::VALUE_W-1:0] radix;
        int                           n;
        if (!alphabet_valid())
        begin
            pending_chars.push_back('{ch: '0, last: 1'b1, bad: 1'b1});
            return;
        end
        radix = sibd_pkg::VALUE_W'(base_len);
        mag = v[sibd_pkg::VALUE_W-1] ? (32'd0 - v) : v;
        n = 0;
        do
        begin
            stack[n] = 4'(mag % radix);
            mag = mag / radix;
            n++;
        end while (mag != 0 && n < sibd_pkg::MAX_DIGITS);
        if (v[sibd_pkg::VALUE_W-1])
            pending_chars.push_back('{ch: sibd_pkg::CHAR_MINUS, last: 1'b0, bad: 1'b0});
        for (int i = n - 1; i >= 0; i--)
            pending_chars.push_back('{ch: alpha_byte(stack[i]), last: (i == 0), bad: 1'b0});
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [sibd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sibd_pkg::ALPHA_WORD_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            sibd_pkg::CFG_BASE_LENGTH: base_len = data[4:0];
            sibd_pkg::CFG_DIGITS_LOW:  alpha_lo = data;
            sibd_pkg::CFG_DIGITS_HIGH: alpha_hi = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_value(input logic [sibd_pkg::VALUE_W-1:0] v, input bit drain);
        number_queue.push_back('{value: v, drain: drain});
    endtask

    task automatic wait_drained();
        while (number_queue.size() != 0 || in_valid || pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random alphabet for the given radix, possibly spoiled in one way.
    task automatic program_alphabet(input int radix, input alpha_flaw_t flaw);
        logic [sibd_pkg::CHAR_W-1:0]       chars [16];
        logic [sibd_pkg::CHAR_W-1:0]       c;
        logic [sibd_pkg::ALPHA_WORD_W-1:0] lo;
        logic [sibd_pkg::ALPHA_WORD_W-1:0] hi;
        logic [sibd_pkg::ALPHA_WORD_W-1:0] base_word;
        bit                                fresh;
        int                                p;
        int                                q;
        for (int i = 0; i < 16; i++)
        begin
            if (i < radix)
            begin
                do
                begin
                    c = 8'($urandom_range(32, 126));
                    fresh = (c != sibd_pkg::CHAR_PLUS && c != sibd_pkg::CHAR_MINUS);
                    for (int j = 0; j < i; j++)
                        if (chars[j] == c)
                            fresh = 0;
                end while (!fresh);
                chars[i] = c;
            end
            else
                chars[i] = 8'($urandom_range(0, 255));  // unused, any byte
        end
        p = $urandom_range(0, radix - 1);
        base_word = {$urandom, $urandom};
        base_word[4:0] = 5'(radix);
        case (flaw)
            ALPHA_PLUS:           chars[p] = sibd_pkg::CHAR_PLUS;
            ALPHA_MINUS:          chars[p] = sibd_pkg::CHAR_MINUS;
            ALPHA_UNPRINTABLE_LO: chars[p] = 8'($urandom_range(0, 31));
            ALPHA_UNPRINTABLE_HI: chars[p] = 8'($urandom_range(127, 255));
            ALPHA_REPEAT:
            begin
                q = (p + $urandom_range(1, radix - 1)) % radix;
                chars[p] = chars[q];
            end
            ALPHA_BAD_RADIX:
                base_word[4:0] = 5'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                         : $urandom_range(17, 31));
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
        begin
            lo[i*8 +: 8] = chars[i];
            hi[i*8 +: 8] = chars[i+8];
        end
        write_reg(sibd_pkg::CFG_BASE_LENGTH, base_word);
        write_reg(sibd_pkg::CFG_DIGITS_LOW, lo);
        write_reg(sibd_pkg::CFG_DIGITS_HIGH, hi);
    endtask

    function automatic logic [sibd_pkg::VALUE_W-1:0] random_value(input int radix);
        logic [sibd_pkg::VALUE_W-1:0] m;
        case ($urandom_range(0, 5))
            0: m = $urandom;
            1: m = $urandom_range(0, radix * radix);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: m = 32'h0000_0000;
                    1: m = 32'h0000_0001;
                    2: m = 32'hFFFF_FFFF;
                    3: m = 32'h8000_0000;
                    default: m = 32'h7FFF_FFFF;
                endcase
                return m;
            end
            3: return $urandom | 32'h8000_0000;
            default: m = $urandom >> $urandom_range(0, 31);
        endcase
        return $urandom_range(0, 1) ? (32'd0 - m) : m;
    endfunction

    // Driver: bursts of transfers with random gaps; drain-marked numbers wait
    // until every outstanding character has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_text(value);
                numbers_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (number_queue.size() != 0 &&
                         !(number_queue[0].drain && pending_chars.size() != 0))
                begin
                    value    <= number_queue[0].value;
                    in_valid <= 1'b1;
                    void'(number_queue.pop_front());
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each character transfer and drives the receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_left = 0;
            rx_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                chars_checked++;
                if (bad_base)
                    rejections_seen++;
                if (pending_chars.size() == 0)
                    report_mismatch("unexpected character",
                                    32'({out_char, last, bad_base}), 32'd0);
                else
                begin
                    want = pending_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch("out_char", 32'(out_char), 32'(want.ch));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                    if (bad_base !== want.bad)
                        report_mismatch("bad_base", 32'(bad_base), 32'(want.bad));
                end
            end
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            else
                rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:     out_ready <= 1'b1;
                RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: out_ready <= (rx_tick % 3 == 0);
                default:
                begin
                    if (rx_hold > 0)
                    begin
                        rx_hold--;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        rx_hold = $urandom_range(0, 12);
                        out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int radix;
        alpha_flaw_t flaw;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset alphabet is all zero bytes: rejected
        queue_value(32'd5, 1'b0);
        queue_value(-32'sd3, 1'b0);
        wait_drained();

        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'd16);
        write_reg(sibd_pkg::CFG_DIGITS_LOW, HEX_LO);
        write_reg(sibd_pkg::CFG_DIGITS_HIGH, HEX_HI);
        settings_used++;
        queue_value(32'h0000_0000, 1'b0);
        queue_value(32'h0000_0001, 1'b0);
        queue_value(32'hFFFF_FFFF, 1'b0);
        queue_value(32'h7FFF_FFFF, 1'b0);
        queue_value(32'h8000_0000, 1'b1);
        queue_value(32'h0000_00FF, 1'b0);
        queue_value(32'hFFFF_FF00, 1'b0);
        wait_drained();

        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'd2);
        write_reg(sibd_pkg::CFG_DIGITS_LOW, EDGE_LO);
        settings_used++;
        queue_value(32'h8000_0000, 1'b0);  // 33 characters
        queue_value(32'h7FFF_FFFF, 1'b0);
        queue_value(32'h0000_0000, 1'b0);
        queue_value(32'hFFFF_FFFF, 1'b0);
        wait_drained();

        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'd10);
        write_reg(sibd_pkg::CFG_DIGITS_LOW, HEX_LO);
        write_reg(sibd_pkg::CFG_DIGITS_HIGH, DEC_HI);
        settings_used++;
        queue_value(32'd123456789, 1'b0);
        queue_value(-32'sd987654321, 1'b0);
        wait_drained();

        // radix out of range, upper data bits ignored
        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
        queue_value(32'd7, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'd1);
        queue_value(32'd7, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'd0);
        queue_value(32'd7, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'h0000_0000_0000_001F);
        queue_value(-32'sd7, 1'b0);
        wait_drained();
        // alphabet flaws at base 10
        write_reg(sibd_pkg::CFG_BASE_LENGTH, 64'd10);
        write_reg(sibd_pkg::CFG_DIGITS_LOW, 64'h3736_3534_2B32_3130);
        queue_value(32'd42, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_DIGITS_LOW, 64'h3736_3534_3332_312D);
        queue_value(32'd42, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_DIGITS_LOW, 64'h3736_3034_3332_3130);
        queue_value(32'd42, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_DIGITS_LOW, 64'h1F36_3534_3332_3130);
        queue_value(32'd42, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_DIGITS_LOW, HEX_LO);
        write_reg(sibd_pkg::CFG_DIGITS_HIGH, 64'h0000_0000_0000_7F38);
        queue_value(32'd42, 1'b0);
        wait_drained();
        write_reg(sibd_pkg::CFG_DIGITS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_value(32'd42, 1'b0);
        wait_drained();
        settings_used += 10;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                radix = 2;
            else if (ph == 1)
                radix = sibd_pkg::MAX_BASE;
            else
                radix = $urandom_range(2, sibd_pkg::MAX_BASE);
            flaw = ALPHA_CLEAN;
            if (ph >= 2 && $urandom_range(0, 4) == 0)
                flaw = alpha_flaw_t'($urandom_range(1, 6));
            program_alphabet(radix, flaw);
            if (ph == 5)
                write_reg(CFG_SPARE, {$urandom, $urandom});  // must change nothing
            settings_used++;
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_value(random_value(radix), $urandom_range(0, 19) == 0);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("%0d numbers converted under %0d register settings", numbers_sent,
                 settings_used);
        $display("%0d characters checked, %0d alphabet rejections, %0d mismatches",
                 chars_checked, rejections_seen, mismatches);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
